/* rtl/bptc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bptc_pkg;

  localparam int SampleW = 24;
  localparam int ScaledW = 26;
  localparam int TempW   = 21;
  localparam int PresW   = 24;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 24;

  // floor(2^28 / 15); a product by it under-estimates y / 15 by less than one.
  localparam logic [24:0] Recip15 = 25'd17895697;
  localparam int RecipShift = 28;

  localparam logic [CfgIdxW-1:0] REG_TEMP_COEFFS = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_C00         = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_C10         = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_C01         = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_C11         = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_C20         = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_C21         = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_C30         = 3'd7;

  typedef struct packed {
    logic [11:0] c0;
    logic [11:0] c1;
    logic [19:0] c00;
    logic [19:0] c10;
    logic [15:0] c01;
    logic [15:0] c11;
    logic [15:0] c20;
    logic [15:0] c21;
    logic [15:0] c30;
  } bptc_coeffs_t;

  typedef struct packed {
    logic [ScaledW-1:0] ps;
    logic [ScaledW-1:0] ts;
  } bptc_scaled_t;

endpackage
`default_nettype wire

/* rtl/bptc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module bptc_front import bptc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [SampleW-1:0] pressure_sample,
  input  wire logic [SampleW-1:0] temperature_sample,
  input  wire logic               q_full,
  output logic                    q_push,
  output bptc_scaled_t            q_data
);

  localparam int YW = SampleW + 5;

  logic               v1_r, v2_r;
  logic               en1, en2;
  logic [SampleW-1:0] p_mag, t_mag;
  logic [YW-1:0]      p_y, t_y;
  logic [53:0]        p_prod, t_prod;
  logic [YW-1:0]      p_y_r, t_y_r;
  logic [ScaledW-1:0] p_q0_r, t_q0_r;
  logic               p_neg_r, t_neg_r;
  logic [ScaledW-1:0] ps_nxt, ts_nxt;
  bptc_scaled_t       out_r;

  // Rounded |raw| * 32 / 15 is floor((|raw| * 32 + 7) / 15).
  assign p_mag  = pressure_sample[SampleW-1] ? (~pressure_sample + 1'b1) : pressure_sample;
  assign t_mag  = temperature_sample[SampleW-1] ?
                  (~temperature_sample + 1'b1) : temperature_sample;
  assign p_y    = {p_mag, 5'b00111};
  assign t_y    = {t_mag, 5'b00111};
  assign p_prod = 54'(p_y) * 54'(Recip15);
  assign t_prod = 54'(t_y) * 54'(Recip15);

  function automatic logic [ScaledW-1:0] fix_q(input logic [YW-1:0] y,
                                               input logic [ScaledW-1:0] q0,
                                               input logic neg);
    logic [ScaledW+3:0] q15;
    logic [ScaledW+3:0] r;
    logic [ScaledW-1:0] q;
    q15 = {q0, 4'b0000} - {4'b0000, q0};
    r   = (ScaledW+4)'(y) - q15;
    q   = (r >= (ScaledW+4)'(15)) ? q0 + 1'b1 : q0;
    return neg ? (~q + 1'b1) : q;
  endfunction

  assign ps_nxt = fix_q(p_y_r, p_q0_r, p_neg_r);
  assign ts_nxt = fix_q(t_y_r, t_q0_r, t_neg_r);

  assign en2      = !v2_r || !q_full;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;
  assign q_push   = v2_r && !q_full;
  assign q_data   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      p_y_r   <= p_y;
      t_y_r   <= t_y;
      p_q0_r  <= p_prod[RecipShift +: ScaledW];
      t_q0_r  <= t_prod[RecipShift +: ScaledW];
      p_neg_r <= pressure_sample[SampleW-1];
      t_neg_r <= temperature_sample[SampleW-1];
    end
    if (en2 && v1_r) begin
      out_r.ps <= ps_nxt;
      out_r.ts <= ts_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/bptc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module bptc_queue import bptc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire bptc_scaled_t push_data,
  output logic              full,
  input  wire logic         pop,
  output bptc_scaled_t      pop_data,
  output logic              empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  bptc_scaled_t  mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign full     = (count_r == CntW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* rtl/bptc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module bptc_back import bptc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire bptc_coeffs_t coeffs,
  input  wire logic         q_empty,
  input  wire bptc_scaled_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [TempW-1:0]  out_temperature,
  output logic [PresW-1:0]  out_pressure,
  output logic              out_clipped
);

  logic signed [11:0] c0, c1;
  logic signed [19:0] c00, c10;
  logic signed [15:0] c01, c11, c20, c21, c30;

  assign c0  = coeffs.c0;
  assign c1  = coeffs.c1;
  assign c00 = coeffs.c00;
  assign c10 = coeffs.c10;
  assign c01 = coeffs.c01;
  assign c11 = coeffs.c11;
  assign c20 = coeffs.c20;
  assign c21 = coeffs.c21;
  assign c30 = coeffs.c30;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic en1, en2, en3, en4, en5, en6, en7;

  // Stage 1: first products.
  logic signed [ScaledW-1:0] qps, qts;
  logic signed [41:0] p30_nxt, p21_nxt, t01_nxt;
  logic signed [37:0] tc1_nxt;
  logic signed [41:0] p30_r, p21_r, t01_r;
  logic signed [37:0] tc1_r;
  logic signed [ScaledW-1:0] ps1_r, ts1_r;

  assign qps     = q_data.ps;
  assign qts     = q_data.ts;
  assign p30_nxt = qps * c30;
  assign p21_nxt = qps * c21;
  assign t01_nxt = qts * c01;
  assign tc1_nxt = qts * c1;

  // Stage 2: a, c, t2 and the temperature accumulator.
  logic signed [33:0] p30s, p21s, t01s;
  logic signed [33:0] a_nxt, c_nxt;
  logic signed [38:0] tacc_nxt;
  logic signed [33:0] a_r, c_r, t2_r;
  logic signed [38:0] tacc_r;
  logic signed [ScaledW-1:0] ps2_r, ts2_r;

  assign p30s     = p30_r[41:8];
  assign p21s     = p21_r[41:8];
  assign t01s     = t01_r[41:8];
  assign a_nxt    = 34'($signed({c20, 16'h0000})) + p30s;
  assign c_nxt    = 34'($signed({c11, 16'h0000})) + p21s;
  assign tacc_nxt = 39'($signed({c0, 23'h0})) + 39'(tc1_r);

  // Stage 3: second products and the temperature result.
  logic signed [59:0] pa_nxt, tc_nxt;
  logic signed [59:0] pa_r, tc_r;
  logic signed [38:0] tround;
  logic signed [22:0] tq;
  logic [TempW-1:0] tsat;
  logic tclip;
  logic [TempW-1:0] t3_r, t4_r, t5_r, t6_r;
  logic tclip3_r, tclip4_r, tclip5_r, tclip6_r;
  logic signed [33:0] t2_3_r, t2_4_r, t2_5_r;
  logic signed [ScaledW-1:0] ps3_r;

  assign pa_nxt = ps2_r * a_r;
  assign tc_nxt = ts2_r * c_r;
  assign tround = tacc_r + 39'sd32768;
  assign tq     = tround[38:16];

  always_comb begin
    tclip = 1'b0;
    tsat  = tq[TempW-1:0];
    if (tq > 23'sd1048575) begin
      tclip = 1'b1;
      tsat  = {1'b0, {(TempW-1){1'b1}}};
    end else if (tq < -23'sd1048576) begin
      tclip = 1'b1;
      tsat  = {1'b1, {(TempW-1){1'b0}}};
    end
  end

  // Stage 4: b and d.
  logic signed [35:0] pas;
  logic signed [36:0] b_nxt, b_r;
  logic signed [35:0] d_r;
  logic signed [ScaledW-1:0] ps4_r;

  assign pas   = pa_r[59:24];
  assign b_nxt = 37'($signed({c10, 16'h0000})) + 37'(pas);

  // Stage 5: final products.
  logic signed [62:0] pb_nxt, pb_r;
  logic signed [61:0] pd_nxt, pd_r;

  assign pb_nxt = ps4_r * b_r;
  assign pd_nxt = ps4_r * d_r;

  // Stage 6: pressure sum.
  logic signed [38:0] pbs;
  logic signed [37:0] pds;
  logic signed [39:0] sum_nxt, sum_r;

  assign pbs     = pb_r[62:24];
  assign pds     = pd_r[61:24];
  assign sum_nxt = 40'($signed({c00, 16'h0000})) + 40'(pbs) + 40'(pds) + 40'(t2_5_r);

  // Stage 7: round, saturate and hold for the consumer.
  logic signed [39:0] pround;
  logic signed [29:0] pq;
  logic [PresW-1:0] psat;
  logic pclip;
  logic [TempW-1:0] tout_r;
  logic [PresW-1:0] pout_r;
  logic clip_r;

  assign pround = sum_r + 40'sd512;
  assign pq     = pround[39:10];

  always_comb begin
    pclip = 1'b0;
    psat  = pq[PresW-1:0];
    if (pq > 30'sd8388607) begin
      pclip = 1'b1;
      psat  = {1'b0, {(PresW-1){1'b1}}};
    end else if (pq < -30'sd8388608) begin
      pclip = 1'b1;
      psat  = {1'b1, {(PresW-1){1'b0}}};
    end
  end

  assign en7 = !v7_r || !out_stall;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign q_pop = en1 && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en1) v1_r <= !q_empty;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p30_r <= p30_nxt;
      p21_r <= p21_nxt;
      t01_r <= t01_nxt;
      tc1_r <= tc1_nxt;
      ps1_r <= qps;
      ts1_r <= qts;
    end
    if (en2 && v1_r) begin
      a_r    <= a_nxt;
      c_r    <= c_nxt;
      t2_r   <= t01s;
      tacc_r <= tacc_nxt;
      ps2_r  <= ps1_r;
      ts2_r  <= ts1_r;
    end
    if (en3 && v2_r) begin
      pa_r     <= pa_nxt;
      tc_r     <= tc_nxt;
      t3_r     <= tsat;
      tclip3_r <= tclip;
      t2_3_r   <= t2_r;
      ps3_r    <= ps2_r;
    end
    if (en4 && v3_r) begin
      b_r      <= b_nxt;
      d_r      <= tc_r[59:24];
      t4_r     <= t3_r;
      tclip4_r <= tclip3_r;
      t2_4_r   <= t2_3_r;
      ps4_r    <= ps3_r;
    end
    if (en5 && v4_r) begin
      pb_r     <= pb_nxt;
      pd_r     <= pd_nxt;
      t5_r     <= t4_r;
      tclip5_r <= tclip4_r;
      t2_5_r   <= t2_4_r;
    end
    if (en6 && v5_r) begin
      sum_r    <= sum_nxt;
      t6_r     <= t5_r;
      tclip6_r <= tclip5_r;
    end
    if (en7 && v6_r) begin
      tout_r <= t6_r;
      pout_r <= psat;
      clip_r <= tclip6_r || pclip;
    end
  end

  assign out_valid       = v7_r;
  assign out_temperature = tout_r;
  assign out_pressure    = pout_r;
  assign out_clipped     = clip_r;

`ifndef SYNTHESIS
  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (v7_r && clip_r) |->
      (tout_r == {1'b0, {(TempW-1){1'b1}}}) || (tout_r == {1'b1, {(TempW-1){1'b0}}}) ||
      (pout_r == {1'b0, {(PresW-1){1'b1}}}) || (pout_r == {1'b1, {(PresW-1){1'b0}}}))
    else $error("clipped set without a saturated output");

  a_tclip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && tclip3_r) |->
      (t3_r == {1'b0, {(TempW-1){1'b1}}}) || (t3_r == {1'b1, {(TempW-1){1'b0}}}))
    else $error("temperature clip without a limit value");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && !en7) |=> v6_r)
    else $error("pipeline stage dropped a beat while blocked");

  a_pop_when_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

/* rtl/baro_pressure_temp_compensation_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one sample pair per cycle when nothing stalls; the front scaler, the queue
// and the seven-stage polynomial pipeline each advance one beat per cycle when not
// held by a full queue or by out_stall.
// Reset (rst_n low, synchronous) empties every stage and the queue and clears all
// coefficient registers to zero. Configuration writes complete in the cycle they are offered.
module baro_pressure_temp_compensation_unit import bptc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [SampleW-1:0] in_pressure_sample,
  input  wire logic [SampleW-1:0] in_temperature_sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [TempW-1:0]        out_temperature_out,
  output logic [PresW-1:0]        out_pressure_out,
  output logic                    out_clipped,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_data
);

  bptc_coeffs_t coeffs_r;
  bptc_scaled_t push_data, pop_data;
  logic q_full, q_empty, q_push, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeffs_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TEMP_COEFFS: begin
          coeffs_r.c0 <= cfg_data[23:12];
          coeffs_r.c1 <= cfg_data[11:0];
        end
        REG_C00: coeffs_r.c00 <= cfg_data[19:0];
        REG_C10: coeffs_r.c10 <= cfg_data[19:0];
        REG_C01: coeffs_r.c01 <= cfg_data[15:0];
        REG_C11: coeffs_r.c11 <= cfg_data[15:0];
        REG_C20: coeffs_r.c20 <= cfg_data[15:0];
        REG_C21: coeffs_r.c21 <= cfg_data[15:0];
        REG_C30: coeffs_r.c30 <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  bptc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .pressure_sample    (in_pressure_sample),
    .temperature_sample (in_temperature_sample),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_data             (push_data)
  );

  bptc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  bptc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .coeffs          (coeffs_r),
    .q_empty         (q_empty),
    .q_data          (pop_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_temperature (out_temperature_out),
    .out_pressure    (out_pressure_out),
    .out_clipped     (out_clipped)
  );

endmodule
`default_nettype wire
